@@ rtl/core/swpc_pkg.sv @@
// shared constants for the pair-collapse stack: command and status codes,
// stream widths and parameter defaults. no dependencies
package swpc_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int OP_W          = 2;
	localparam int STATUS_W      = 2;
	localparam int VALUE_W       = 32;
	localparam int COUNT_W       = 7;
	localparam int IN_TDATA_W    = 32;
	localparam int OUT_TDATA_W   = 40;

	localparam logic [OP_W-1:0] OP_PUSH     = 2'd0;
	localparam logic [OP_W-1:0] OP_POP      = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK     = 2'd2;
	localparam logic [OP_W-1:0] OP_COLLAPSE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

@@ rtl/core/stack_with_pair_collapse_top.sv @@
// bounded lifo stack with push, pop, peek and pair collapse over a stream port
// depends on swpc_pkg and swpc_ram
// push goes straight to done; pop and peek take the top entry from the ram in S_RD_TOP;
// collapse sums the n stored entries pair by pair through S_C_RD0, S_C_RD1
// and S_C_WR (one shared adder, one ram read port); empty pop, peek and
// collapse go straight to done. commands are taken only in idle, but a finished
// result may wait in the output register while the next item is accepted
// arst_n clears the fill count, sequencer and output valid; ram contents are not cleared
module stack_with_pair_collapse_top #(
	parameter int DEPTH      = swpc_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = swpc_pkg::DATA_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [swpc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // push_value[31:0]
	input  logic [swpc_pkg::OP_W-1:0]          s_axis_tuser,  // op[1:0]
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [swpc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // value[31:0], count[38:32], pad
	output logic [swpc_pkg::STATUS_W-1:0]      m_axis_tuser   // status[1:0]
);

	import swpc_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_RD_TOP = 3'd1;
	localparam logic [2:0] S_C_RD0  = 3'd2;
	localparam logic [2:0] S_C_RD1  = 3'd3;
	localparam logic [2:0] S_C_WR   = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0]            state_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         newn_q;
	logic [CW-1:0]         k_q;
	logic [AW-1:0]         p_q;
	logic [DATA_WIDTH-1:0] a_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic [VALUE_W-1:0]    res_value_q;
	logic                  out_valid_q;

	logic                  in_xfer;
	logic                  out_free;
	logic                  is_empty;
	logic                  is_full;
	logic [CW:0]           cnt_inc;
	logic [CW-1:0]         cnt_half;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [AW-1:0]         rd_addr;
	logic [DATA_WIDTH-1:0] rd_data;
	logic [AW-1:0]         top_addr;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign is_empty      = (cnt_q == '0);
	assign is_full       = (cnt_q == CW'(DEPTH));
	assign cnt_inc       = {1'b0, cnt_q} + (CW+1)'(1);
	assign cnt_half      = cnt_inc[CW:1];
	assign top_addr      = AW'(cnt_q - CW'(1));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[AW-1:0];
		wr_data = DATA_WIDTH'($signed(s_axis_tdata));
		rd_addr = top_addr;
		unique case (state_q)
			S_IDLE: begin
				wr_en = in_xfer && (s_axis_tuser == OP_PUSH) && !is_full;
			end
			S_C_RD0: begin
				rd_addr = p_q;
			end
			S_C_RD1: begin
				rd_addr = p_q + AW'(1);
			end
			S_C_WR: begin
				wr_en   = 1'b1;
				wr_addr = k_q[AW-1:0];
				wr_data = a_q + rd_data;
			end
			default: begin
			end
		endcase
	end

	swpc_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			newn_q  <= '0;
			k_q     <= '0;
			p_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						unique case (s_axis_tuser)
							OP_PUSH: begin
								if (!is_full) begin
									cnt_q <= CW'(cnt_inc);
								end
								state_q <= S_DONE;
							end
							OP_POP: begin
								if (is_empty) begin
									state_q <= S_DONE;
								end else begin
									cnt_q   <= cnt_q - CW'(1);
									state_q <= S_RD_TOP;
								end
							end
							OP_PEEK: begin
								state_q <= is_empty ? S_DONE : S_RD_TOP;
							end
							OP_COLLAPSE: begin
								if (is_empty) begin
									state_q <= S_DONE;
								end else begin
									newn_q  <= cnt_half;
									k_q     <= CW'(cnt_q[0]);
									p_q     <= AW'(cnt_q[0]);
									state_q <= S_C_RD0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RD_TOP: begin
					state_q <= S_DONE;
				end
				S_C_RD0: begin
					if (k_q >= newn_q) begin
						cnt_q   <= newn_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_C_RD1;
					end
				end
				S_C_RD1: begin
					state_q <= S_C_WR;
				end
				S_C_WR: begin
					k_q     <= k_q + CW'(1);
					p_q     <= p_q + AW'(2);
					state_q <= S_C_RD0;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload, captured as the command resolves
	always_ff @(posedge clk) begin
		if (state_q == S_C_RD1) begin
			a_q <= rd_data;
		end
		if (state_q == S_IDLE && in_xfer) begin
			res_value_q  <= '0;
			res_status_q <= ST_OK;
			if (s_axis_tuser == OP_PUSH) begin
				if (is_full) begin
					res_status_q <= ST_FULL;
				end
			end else if (is_empty) begin
				res_status_q <= ST_EMPTY;
			end
		end
		if (state_q == S_RD_TOP) begin
			res_value_q <= VALUE_W'(rd_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			m_axis_tdata <= {1'b0, COUNT_W'(cnt_q), res_value_q};
			m_axis_tuser <= res_status_q;
		end
	end

endmodule

@@ rtl/core/swpc_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module swpc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ rtl/core/swpc_checker.sv @@
// port-level checks for the pair-collapse stack, bound to the top level
// depends on swpc_pkg and stack_with_pair_collapse_top
module swpc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [swpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [swpc_pkg::STATUS_W-1:0]    m_axis_tuser
);

	import swpc_pkg::*;

	// one command at a time
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after a transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_EMPTY ||
			m_axis_tuser == ST_FULL))
		else $error("undefined status");

	a_fail_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[31:0] == '0)
		else $error("nonzero value with failing status");

	a_empty_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_EMPTY |-> m_axis_tdata[38:32] == '0)
		else $error("empty status with nonzero count");

endmodule

bind stack_with_pair_collapse_top swpc_checker u_swpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
